### rtl/core/scfr_pkg.sv
// shared types, constants and functions of the serial command frame receiver
package scfr_pkg;

    // default sizes
    localparam int MAX_FRAME_DEF       = 64;
    localparam int THRESHOLD_BYTES_DEF = 20;

    // frame header bytes captured in registers: command, register, lsb, msb, crc, sequence
    localparam int HDR_BYTES = 6;

    // framing and command codes
    localparam logic [7:0] PREAMBLE      = 8'hAA;
    localparam logic [7:0] CMD_WRITE_ALL = 8'h02;
    localparam logic [7:0] CMD_WRITE_DEV = 8'h04;

    // known device registers
    localparam logic [7:0] REG_CELL_A = 8'h20;
    localparam logic [7:0] REG_CELL_B = 8'h21;
    localparam logic [7:0] REG_CELL_C = 8'h22;
    localparam logic [7:0] REG_TEMP_A = 8'h30;
    localparam logic [7:0] REG_TEMP_B = 8'h31;
    localparam logic [7:0] REG_TEMP_C = 8'h32;

    localparam logic [7:0] SEQ_NONE = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'hB2;

    // result status codes
    typedef enum logic [2:0] {
        ST_REG_OK       = 3'd0,
        ST_UNKNOWN_REG  = 3'd1,
        ST_BAD_CRC      = 3'd2,
        ST_SHORT        = 3'd3,
        ST_WRITE_ALL    = 3'd4,
        ST_UNKNOWN_CMD  = 3'd5,
        ST_BAD_SUM      = 3'd6,
        ST_BAD_LENGTH   = 3'd7
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_PREAMBLE,
        S_LENGTH,
        S_DATA,
        S_CHECK,
        S_CRC,
        S_CRC_DONE,
        S_COPY,
        S_EMIT
    } state_t;

    // one result transaction
    typedef struct packed {
        status_t             status;
        logic [7:0]          command_code;
        logic [7:0]          register_code;
        logic signed [15:0]  raw_value;
        logic [7:0]          sequence_number;
        logic                replay_seen;
        logic [5:0]          payload_length;
        logic                threshold_overflow;
        logic [7:0]          crc_computed;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic take_length;
        logic take_data;
        logic take_check;
        logic crc_step;
        logic crc_finish;
        logic copy_step;
        logic emit;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic is_preamble;
        logic len_bad;
        logic data_last;
        logic sum_ok;
        logic cmd_write_all;
        logic cmd_write_dev;
        logic dev_short;
        logic copy_none;
        logic copy_last;
        logic crc_last;
        logic out_free;
    } stat_t;

    // one byte of reflected crc-8, bit at a time
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // little-endian float bytes of 420.0, 300.0, 80.0, 60.0, 0.0
    function automatic logic [7:0] default_threshold(input int unsigned idx);
        logic [7:0] v;
        case (idx)
            2:       v = 8'hD2;
            3:       v = 8'h43;
            6:       v = 8'h96;
            7:       v = 8'h43;
            10:      v = 8'hA0;
            11:      v = 8'h42;
            14:      v = 8'h70;
            15:      v = 8'h42;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/scfr_ifs.sv
// valid/ready channel interfaces for received bytes and frame results
interface scfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         command_code;
    logic [7:0]         register_code;
    logic signed [15:0] raw_value;
    logic [7:0]         sequence_number;
    logic               replay_seen;
    logic [5:0]         payload_length;
    logic               threshold_overflow;
    logic [7:0]         crc_computed;

    modport source (
        output valid, input ready,
        output status, output command_code, output register_code, output raw_value,
        output sequence_number, output replay_seen, output payload_length,
        output threshold_overflow, output crc_computed
    );
    modport sink (
        input valid, output ready,
        input status, input command_code, input register_code, input raw_value,
        input sequence_number, input replay_seen, input payload_length,
        input threshold_overflow, input crc_computed
    );
endinterface

### rtl/core/scfr_ctrl.sv
// frame parser and end-of-frame sequencer state machine
module scfr_ctrl
    import scfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output ctrl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PREAMBLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = (state_reg == S_PREAMBLE) || (state_reg == S_LENGTH) ||
                     (state_reg == S_DATA) || (state_reg == S_CHECK);
        accept     = in_ready && in_valid;

        unique case (state_reg)
            S_PREAMBLE:
            begin
                if (accept && stat.is_preamble)
                begin
                    state_next = S_LENGTH;
                end
            end
            S_LENGTH:
            begin
                if (accept)
                begin
                    ctl.take_length = 1'b1;
                    state_next      = stat.len_bad ? S_EMIT : S_DATA;
                end
            end
            S_DATA:
            begin
                if (accept)
                begin
                    ctl.take_data = 1'b1;
                    if (stat.data_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (accept)
                begin
                    ctl.take_check = 1'b1;
                    priority if (!stat.sum_ok)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (stat.cmd_write_all)
                    begin
                        state_next = stat.copy_none ? S_EMIT : S_COPY;
                    end
                    else if (stat.cmd_write_dev)
                    begin
                        state_next = stat.dev_short ? S_EMIT : S_CRC;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_CRC:
            begin
                ctl.crc_step = 1'b1;
                if (stat.crc_last)
                begin
                    state_next = S_CRC_DONE;
                end
            end
            S_CRC_DONE:
            begin
                ctl.crc_finish = 1'b1;
                state_next     = S_EMIT;
            end
            S_COPY:
            begin
                ctl.copy_step = 1'b1;
                if (stat.copy_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_PREAMBLE;
                end
            end
            default:
            begin
                state_next = S_PREAMBLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // crc finish always hands straight over to the emit state
    a_crc_done_to_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC_DONE) |=> (state_reg == S_EMIT)
    ) else $error("crc finish not followed by emit");

    // a loaded result returns the parser to preamble search
    a_emit_to_preamble: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.emit |=> (state_reg == S_PREAMBLE)
    ) else $error("parser not back at preamble after emit");

    // a result waiting on a held slot keeps the controller in emit
    a_emit_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && !stat.out_free) |=> (state_reg == S_EMIT)
    ) else $error("emit left before the result slot freed");
`endif

endmodule

### rtl/core/scfr_datapath.sv
// frame store, checksum, crc unit, threshold image and result registers
module scfr_datapath
    import scfr_pkg::*;
#(
    parameter int MAX_FRAME       = MAX_FRAME_DEF,
    parameter int THRESHOLD_BYTES = THRESHOLD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       out_ready,
    input  ctrl_t      ctl,
    output stat_t      stat,
    output logic       out_valid,
    output result_t    out_data
);

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int IDX_W  = $clog2(MAX_FRAME + 1);
    localparam int TH_AW  = (THRESHOLD_BYTES > 1) ? $clog2(THRESHOLD_BYTES) : 1;
    localparam int CP_W   = $clog2(THRESHOLD_BYTES + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);
    localparam logic [7:0] TH_LEN  = 8'(THRESHOLD_BYTES);

    // parser state
    logic [7:0]       exp_len_reg;
    logic [IDX_W-1:0] byte_idx_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       last_seq_reg;
    logic [7:0]       hdr_reg [HDR_BYTES];

    // frame store and copy engine
    logic [7:0]       frame_mem [MAX_FRAME];
    logic [7:0]       rdata_reg;
    logic [CP_W-1:0]  copy_cnt_reg;
    logic             copy_pend_reg;
    logic [TH_AW-1:0] copy_widx_reg;
    logic [7:0]       thresh_reg [THRESHOLD_BYTES];

    // crc unit
    logic [7:0]       crc_reg;
    logic [1:0]       crc_cnt_reg;

    // result staging and output slot
    result_t          res_reg;
    result_t          out_reg;
    logic             out_valid_reg;

    logic [7:0]        plen;
    logic [7:0]        copy_n;
    logic [8:0]        idx_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        crc_byte;
    logic              has_seq;
    logic              crc_ok;
    logic              reg_known;
    logic              out_free;
    result_t           res_len;
    result_t           res_chk;
    result_t           res_crc;

    assign plen     = exp_len_reg - 8'd1;
    assign copy_n   = (plen > TH_LEN) ? TH_LEN : plen;
    assign idx_inc  = 9'(byte_idx_reg) + 9'd1;
    assign rd_addr  = ADDR_W'(copy_cnt_reg) + ADDR_W'(1);
    assign has_seq  = plen > 8'd4;
    assign crc_ok   = crc_reg == hdr_reg[4];
    assign out_free = !out_valid_reg || out_ready;

    // crc input byte for each step
    always_comb
    begin
        unique case (crc_cnt_reg)
            2'd0:    crc_byte = CMD_WRITE_DEV;
            2'd1:    crc_byte = hdr_reg[1];
            2'd2:    crc_byte = hdr_reg[2];
            2'd3:    crc_byte = hdr_reg[3];
            default: crc_byte = CMD_WRITE_DEV;
        endcase
    end

    // known register decode
    always_comb
    begin
        unique case (hdr_reg[1])
            REG_CELL_A, REG_CELL_B, REG_CELL_C,
            REG_TEMP_A, REG_TEMP_B, REG_TEMP_C: reg_known = 1'b1;
            default:                             reg_known = 1'b0;
        endcase
    end

    // status toward the controller
    always_comb
    begin
        stat.is_preamble   = rx_byte == PREAMBLE;
        stat.len_bad       = (rx_byte == 8'd0) || (rx_byte > MAX_LEN);
        stat.data_last     = idx_inc >= {1'b0, exp_len_reg};
        stat.sum_ok        = sum_reg == rx_byte;
        stat.cmd_write_all = hdr_reg[0] == CMD_WRITE_ALL;
        stat.cmd_write_dev = hdr_reg[0] == CMD_WRITE_DEV;
        stat.dev_short     = plen < 8'd4;
        stat.copy_none     = plen == 8'd0;
        stat.copy_last     = (9'(copy_cnt_reg) + 9'd1) >= {1'b0, copy_n};
        stat.crc_last      = crc_cnt_reg == 2'd3;
        stat.out_free      = out_free;
    end

    // result for a bad length byte
    always_comb
    begin
        res_len                 = '0;
        res_len.status          = ST_BAD_LENGTH;
        res_len.sequence_number = SEQ_NONE;
    end

    // result decided at the checksum byte
    always_comb
    begin
        res_chk                 = '0;
        res_chk.sequence_number = SEQ_NONE;
        res_chk.command_code    = hdr_reg[0];
        res_chk.payload_length  = plen[5:0];
        priority if (!stat.sum_ok)
        begin
            res_chk.status = ST_BAD_SUM;
        end
        else if (stat.cmd_write_all)
        begin
            res_chk.status             = ST_WRITE_ALL;
            res_chk.threshold_overflow = plen > TH_LEN;
        end
        else if (stat.cmd_write_dev)
        begin
            res_chk.status = stat.dev_short ? ST_SHORT : ST_BAD_CRC;
        end
        else
        begin
            res_chk.status = ST_UNKNOWN_CMD;
        end
    end

    // write-device fields once the crc is done
    always_comb
    begin
        res_crc                 = res_reg;
        res_crc.register_code   = hdr_reg[1];
        res_crc.raw_value       = {hdr_reg[3], hdr_reg[2]};
        res_crc.sequence_number = has_seq ? hdr_reg[5] : SEQ_NONE;
        res_crc.crc_computed    = crc_reg;
        res_crc.replay_seen     = 1'b0;
        if (!crc_ok)
        begin
            res_crc.status = ST_BAD_CRC;
        end
        else
        begin
            res_crc.replay_seen = has_seq && (hdr_reg[5] == last_seq_reg);
            res_crc.status      = reg_known ? ST_REG_OK : ST_UNKNOWN_REG;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg   <= '0;
            byte_idx_reg  <= '0;
            sum_reg       <= '0;
            last_seq_reg  <= '0;
            crc_cnt_reg   <= '0;
            copy_cnt_reg  <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THRESHOLD_BYTES; i++)
            begin
                thresh_reg[i] <= default_threshold(i);
            end
        end
        else
        begin
            if (ctl.take_length)
            begin
                exp_len_reg  <= rx_byte;
                byte_idx_reg <= '0;
                sum_reg      <= '0;
            end
            if (ctl.take_data)
            begin
                byte_idx_reg <= byte_idx_reg + IDX_W'(1);
                sum_reg      <= sum_reg + rx_byte;
            end
            if (ctl.take_check)
            begin
                crc_cnt_reg  <= '0;
                copy_cnt_reg <= '0;
            end
            if (ctl.crc_step)
            begin
                crc_cnt_reg <= crc_cnt_reg + 2'd1;
            end
            if (ctl.crc_finish && crc_ok && has_seq)
            begin
                last_seq_reg <= hdr_reg[5];
            end
            if (ctl.copy_step)
            begin
                copy_cnt_reg <= copy_cnt_reg + CP_W'(1);
            end
            copy_pend_reg <= ctl.copy_step;
            // write-all copy, one byte a cycle, each written in the cycle after its store read
            if (copy_pend_reg)
            begin
                thresh_reg[copy_widx_reg] <= rdata_reg;
            end
            // output slot
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            if (ctl.take_data && (byte_idx_reg == IDX_W'(k)))
            begin
                hdr_reg[k] <= rx_byte;
            end
        end
        if (ctl.take_check)
        begin
            crc_reg <= 8'd0;
        end
        else if (ctl.crc_step)
        begin
            crc_reg <= crc8_step(crc_reg, crc_byte);
        end
        copy_widx_reg <= TH_AW'(copy_cnt_reg);
        priority if (ctl.take_length)
        begin
            res_reg <= res_len;
        end
        else if (ctl.take_check)
        begin
            res_reg <= res_chk;
        end
        else if (ctl.crc_finish)
        begin
            res_reg <= res_crc;
        end
        if (ctl.emit)
        begin
            out_reg <= res_reg;
        end
    end

    // frame store memory
    always_ff @(posedge clk)
    begin
        if (ctl.take_data)
        begin
            frame_mem[byte_idx_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (ctl.copy_step)
        begin
            rdata_reg <= frame_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // the controller only loads the output slot when it is free
    a_emit_slot_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!out_valid_reg || out_ready)
    ) else $error("result loaded over an untaken transaction");

    // data bytes never run past the announced length
    a_data_in_length: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.take_data |-> (9'(byte_idx_reg) < {1'b0, exp_len_reg})
    ) else $error("data byte beyond frame length");

    // copy reads stay within the clipped payload
    a_copy_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.copy_step |-> (9'(copy_cnt_reg) < {1'b0, copy_n})
    ) else $error("threshold copy out of range");
`endif

endmodule

### rtl/core/serial_command_frame_receiver.sv
// top level: serial command frame receiver with crc-8 checked device writes
// result path: once its checksum or bad length byte is taken, a result passes the emit state into
//   the output slot register; on a good sum, write-device with 4 or more payload bytes first runs
//   4 crc steps and a finish; write-all first copies min(payload, 20) bytes to the threshold image
// throughput: one byte per cycle inside a frame; input pauses after a bad length byte or a
//   checksum byte through the crc or copy steps, the emit state and any wait for the result slot
// reset: parser waits for preamble, counters, sum and last sequence clear, threshold image
//   loads its default bytes at once; the frame store needs no clearing
module serial_command_frame_receiver
    import scfr_pkg::*;
#(
    parameter int MAX_FRAME       = MAX_FRAME_DEF,
    parameter int THRESHOLD_BYTES = THRESHOLD_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    scfr_rx_if.sink       rx,
    scfr_result_if.source result
);

    ctrl_t   ctl;
    stat_t   stat;
    logic    in_ready;
    logic    out_valid;
    result_t out_data;

    scfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    scfr_datapath #(
        .MAX_FRAME       (MAX_FRAME),
        .THRESHOLD_BYTES (THRESHOLD_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx.rx_byte),
        .out_ready (result.ready),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // channel hookup
    assign rx.ready                  = in_ready;
    assign result.valid              = out_valid;
    assign result.status             = out_data.status;
    assign result.command_code       = out_data.command_code;
    assign result.register_code      = out_data.register_code;
    assign result.raw_value          = out_data.raw_value;
    assign result.sequence_number    = out_data.sequence_number;
    assign result.replay_seen        = out_data.replay_seen;
    assign result.payload_length     = out_data.payload_length;
    assign result.threshold_overflow = out_data.threshold_overflow;
    assign result.crc_computed       = out_data.crc_computed;

endmodule
